// ----- sv/gaussian_exp_table_interp_core_assert.svh -----
// Assertion macros used by the RTL of the gaussian table core.
`ifndef GAUSSIAN_EXP_TABLE_INTERP_CORE_ASSERT_SVH
`define GAUSSIAN_EXP_TABLE_INTERP_CORE_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define GEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check, also active during reset.
`define GEXP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/gexp_pkg.sv -----
package gexp_pkg;

    localparam int TABLE_ENTRIES = 100;

    localparam int X_W     = 16;
    localparam int Y_W     = 16;
    localparam int MAG_W   = X_W + 1;
    localparam int P_W     = MAG_W + 5;
    localparam int FRAC_W  = 12;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int VAL_W   = 16;
    localparam int SLOPE_W = 11;
    localparam int PROD_W  = FRAC_W + SLOPE_W + 1;

    localparam logic [P_W-1:0]    P_LIMIT    = P_W'(TABLE_ENTRIES * (1 << FRAC_W));
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));
    localparam logic [Y_W-1:0]    Y_ONE      = Y_W'(1 << (Y_W - 1));

    // exp(-1/800) in Q31, rounded half up
    localparam logic [63:0] Q1_Q31   = 64'd2144800970;
    localparam logic [63:0] HALF_Q31 = 64'd1 << 30;
    localparam logic [63:0] ONE_Q31  = 64'd1 << 31;

    typedef logic [63:0]        work_rom_t  [TABLE_ENTRIES];
    typedef logic [VAL_W-1:0]   val_rom_t   [TABLE_ENTRIES];
    typedef logic [SLOPE_W-1:0] slope_rom_t [TABLE_ENTRIES];

    // Q31 samples of exp(-x*x/2) at x = 0.05*i, by the running product v(i) = v(i-1)*r
    function automatic work_rom_t build_work_rom();
        work_rom_t  rom;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] q2;
        int          i;
        q2 = (Q1_Q31 * Q1_Q31 + HALF_Q31) >> 31;
        v  = ONE_Q31;
        r  = Q1_Q31;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (i > 0) begin
                v = (v * r + HALF_Q31) >> 31;
                r = (r * q2 + HALF_Q31) >> 31;
            end
            rom[i] = v;
        end
        return rom;
    endfunction

    localparam work_rom_t WORK_ROM = build_work_rom();

    function automatic val_rom_t build_val_rom();
        val_rom_t rom;
        int       i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = VAL_W'((WORK_ROM[i] + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    // slope magnitude prescaled by the 0.05 interval width
    function automatic slope_rom_t build_slope_rom();
        slope_rom_t rom;
        int         i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = SLOPE_W'((64'(i) * WORK_ROM[i] + 64'd13107200) / 64'd26214400);
        end
        return rom;
    endfunction

    localparam val_rom_t   VAL_ROM   = build_val_rom();
    localparam slope_rom_t SLOPE_ROM = build_slope_rom();

endpackage

// ----- sv/gexp_interp.sv -----
module gexp_interp
    import gexp_pkg::*;
(
    input  logic signed [X_W-1:0] x_value,
    output logic        [Y_W-1:0] gauss_value
);

    logic [MAG_W-1:0]   mag;
    logic [P_W-1:0]     p;
    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic [FRAC_W-1:0]  frac;
    logic [VAL_W-1:0]   val;
    logic [SLOPE_W-1:0] slope;
    logic [PROD_W-1:0]  prod;
    logic [VAL_W-1:0]   dec;

    always_comb begin
        mag      = x_value[X_W-1] ? MAG_W'(-MAG_W'(x_value)) : MAG_W'(x_value);
        p        = (P_W'(mag) << 4) + (P_W'(mag) << 2);
        in_range = p < P_LIMIT;
        idx      = in_range ? p[FRAC_W +: IDX_W] : '0;
        frac     = p[FRAC_W-1:0];
        val      = VAL_ROM[idx];
        slope    = SLOPE_ROM[idx];
        prod     = PROD_W'(frac) * PROD_W'(slope) + ROUND_HALF;
        dec      = VAL_W'(prod[PROD_W-1:FRAC_W]);
        if (!in_range || dec >= val) begin
            gauss_value = '0;
        end else begin
            gauss_value = Y_W'(val - dec);
        end
    end

endmodule

// ----- sv/gaussian_exp_table_interp_core.sv -----
// channel   | direction | tdata (lowest bit up)           | tuser / tlast
// s_axis    | in        | [15:0] x_value, signed Q4.12     | none
// m_axis    | out       | [15:0] gauss_value, Q1.15        | none
//
// One item per cycle sustained while m_tready does not stall the output.
// The lookup and multiply-add sit between the input register and the result register.
// aresetn is synchronous, active low, and empties both registers.
// A stall on m_tready holds the result; an empty input register still takes one more item.
`include "gaussian_exp_table_interp_core_assert.svh"

module gaussian_exp_table_interp_core
    import gexp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [X_W-1:0] s_tdata,   // [15:0] x_value
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [Y_W-1:0] m_tdata    // [15:0] gauss_value
);

    logic                  in_valid_reg;
    logic signed [X_W-1:0] x_value_reg;
    logic                  m_tvalid_reg;
    logic [Y_W-1:0]        gauss_value_reg;
    logic [Y_W-1:0]        gauss_value;
    logic                  advance;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = gauss_value_reg;

    gexp_interp u_interp (
        .x_value     (x_value_reg),
        .gauss_value (gauss_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_tvalid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            x_value_reg <= $signed(s_tdata);
        end
        if (advance && in_valid_reg) begin
            gauss_value_reg <= gauss_value;
        end
    end

    `GEXP_ASSERT(a_in_hold, in_valid_reg && !advance |=> in_valid_reg, "input item lost")
    `GEXP_ASSERT(a_in_load, s_tvalid && s_tready |=> in_valid_reg, "transfer not captured")
    `GEXP_ASSERT(a_out_load, in_valid_reg && advance |=> m_tvalid_reg, "result not produced")
    `GEXP_ASSERT(a_zero_arg, in_valid_reg && advance && x_value_reg == '0 |=> m_tdata == Y_ONE, "exp(0) is not one")
    `GEXP_ASSERT(a_range, m_tvalid |-> m_tdata <= Y_ONE, "result above one")

endmodule

// ----- sim/gaussian_exp_table_interp_core_tb.sv -----
module gaussian_exp_table_interp_core_tb;
    import gexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM   = 1700;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } gauss_pair_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [X_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [Y_W-1:0] m_tdata;

    logic [15:0]    gauss_rom_val   [TABLE_ENTRIES];
    logic [15:0]    gauss_rom_slope [TABLE_ENTRIES];

    logic [X_W-1:0] x_pending [$];
    gauss_pair_t    gauss_expected [$];
    logic           s_fire = 1'b0;
    int             in_gap = 0;
    int             out_gap = 0;
    int             mismatches = 0;

    gaussian_exp_table_interp_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [Y_W-1:0] gauss_of(logic [X_W-1:0] x);
        logic [16:0] mag;
        logic [21:0] p;
        int          idx;
        logic [31:0] frac;
        logic [31:0] dec;
        logic [31:0] val;
        logic [31:0] y;
        mag = x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
        p   = 22'(mag) * 22'd20;
        if (32'(p) >= 32'(TABLE_ENTRIES) * 32'd4096)
            return '0;
        idx  = int'(p >> 12);
        if (idx >= TABLE_ENTRIES)
            idx = TABLE_ENTRIES - 1;
        frac = 32'(p[11:0]);
        val  = 32'(gauss_rom_val[idx]);
        dec  = (frac * 32'(gauss_rom_slope[idx]) + 32'd2048) >> 12;
        y    = (dec >= val) ? 32'd0 : val - dec;
        if (y > 32'd32768)
            y = 32'd32768;
        return y[Y_W-1:0];
    endfunction

    function automatic bit idling_allowed();
        int left;
        left = x_pending.size();
        return (left >= TAIL_ITEMS) && ((left / 100) % 3 != 0);
    endfunction

    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            gauss_expected.push_back('{x: s_tdata, y: gauss_of(s_tdata)});
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold until the transfer completes
        end else if (in_gap > 0) begin
            s_tvalid <= 1'b0;
            in_gap--;
        end else if (x_pending.size() > 0) begin
            if (idling_allowed() && $urandom_range(0, 6) == 0) begin
                s_tvalid <= 1'b0;
                in_gap = $urandom_range(0, 5);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= x_pending.pop_front();
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            m_tready <= 1'b0;
            out_gap--;
        end else if (idling_allowed() && $urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            out_gap = $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        gauss_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (gauss_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, m_tdata);
                mismatches++;
            end else begin
                want = gauss_expected.pop_front();
                if (m_tdata !== want.y) begin
                    $display("%0t: gauss_value for x=%0d, expected %0d, actual %0d",
                             $time, $signed(want.x), want.y, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        bit [63:0] term;
        bit [63:0] sum;
        bit [63:0] n;
        bit [63:0] q1;
        bit [63:0] q2;
        bit [63:0] v;
        bit [63:0] r;
        int        directed_x[$];
        int        mag;
        int        xv;

        // exp(-1/800) by alternating series in Q60, then running products in Q31
        term = 64'd1 << 60;
        sum  = term;
        n    = 64'd1;
        while (term != 0 && n < 64) begin
            term = term / (64'd800 * n);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
            n++;
        end
        q1 = (sum + (64'd1 << 28)) >> 29;
        q2 = (q1 * q1 + (64'd1 << 30)) >> 31;
        v  = 64'd1 << 31;
        r  = q1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i > 0) begin
                v = (v * r + (64'd1 << 30)) >> 31;
                r = (r * q2 + (64'd1 << 30)) >> 31;
            end
            gauss_rom_val[i]   = 16'((v + 64'd32768) >> 16);
            gauss_rom_slope[i] = 16'((64'(i) * v + 64'd13107200) / 64'd26214400);
        end

        directed_x = '{0, 1, -1, 32767, -32768, -32767, 20479, -20479, 20480, -20480,
                       20481, 1024, -1024, 1023, 1025, 4096, 204, 205, 10240, -12345,
                       20300, 20470, 21845, -21846, 16'h7f00};
        foreach (directed_x[k])
            x_pending.push_back(16'(directed_x[k]));
        repeat (NUM_RANDOM) begin
            if ($urandom_range(0, 4) != 0) begin
                mag = $urandom_range(0, 20479);
                xv  = $urandom_range(0, 1) ? -mag : mag;
            end else begin
                xv = $urandom_range(0, 65535);
            end
            x_pending.push_back(16'(xv));
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (x_pending.size() > 0 || (s_tvalid && !s_fire))
            @(posedge aclk);
        @(posedge aclk);
        while (gauss_expected.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && gauss_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
